### hw/rtl/osch_pkg.sv
// ----------------------------------------------------------------------------
// osch_pkg
// Shared types, codes and helpers of the oldest-first class-limited scheduler.
// ----------------------------------------------------------------------------
package osch_pkg;

    localparam int ID_W           = 16;
    localparam int CLS_W          = 3;
    localparam int TIME_W         = 32;
    localparam int LIM_W          = 8;
    localparam int CMD_FIFO_DEPTH = 2;

    typedef enum logic [1:0] {
        OP_SUBMIT   = 2'd0,
        OP_GRANT    = 2'd1,
        OP_COMPLETE = 2'd2,
        OP_CANCEL   = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        STS_OK           = 3'd0,
        STS_NOT_FOUND    = 3'd1,
        STS_NONE_ELIGIBLE = 3'd2,
        STS_FULL         = 3'd3,
        STS_INVALID      = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        STG_FREE    = 3'd0,
        STG_QUEUED  = 3'd1,
        STG_RUN     = 3'd2,
        STG_RUN_ADV = 3'd3,
        STG_DONE    = 3'd4
    } rec_stage_t;

    typedef enum logic [1:0] {
        FS_QUEUED  = 2'd0,
        FS_RUNNING = 2'd1,
        FS_DONE    = 2'd2
    } found_stage_t;

    typedef struct packed {
        op_t               op;
        logic [ID_W-1:0]   id;
        logic [CLS_W-1:0]  cls;
        logic [TIME_W-1:0] ctime;
        logic [LIM_W-1:0]  limit;
        logic              bad;
    } cmd_t;

    typedef struct packed {
        status_t           status;
        logic [ID_W-1:0]   id;
        logic [CLS_W-1:0]  cls;
        logic [TIME_W-1:0] ctime;
        found_stage_t      fstage;
        logic              raised;
    } res_t;

    // A new limit counts as raised when it is unlimited or above a finite old one.
    function automatic logic limit_raised(input logic [LIM_W-1:0] old_lim,
                                          input logic [LIM_W-1:0] new_lim);
        return (old_lim != new_lim) &&
               ((new_lim == '0) || ((old_lim != '0) && (new_lim > old_lim)));
    endfunction

endpackage

### hw/rtl/osch_ifs.sv
// ----------------------------------------------------------------------------
// osch_ifs
// Request and response channel interfaces with valid/ready handshake.
// ----------------------------------------------------------------------------
interface osch_req_if
    import osch_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [1:0]        op;
    logic [ID_W-1:0]   request_id;
    logic [CLS_W-1:0]  class_id;
    logic [TIME_W-1:0] create_time;
    logic [LIM_W-1:0]  class_limit;

    modport source (output valid, op, request_id, class_id, create_time, class_limit,
                    input ready);
    modport sink   (input valid, op, request_id, class_id, create_time, class_limit,
                    output ready);
endinterface

interface osch_rsp_if
    import osch_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [2:0]        status;
    logic [ID_W-1:0]   granted_id;
    logic [CLS_W-1:0]  granted_class;
    logic [TIME_W-1:0] granted_time;
    logic [1:0]        found_stage;
    logic              limit_raised;

    modport source (output valid, status, granted_id, granted_class, granted_time,
                    found_stage, limit_raised, input ready);
    modport sink   (input valid, status, granted_id, granted_class, granted_time,
                    found_stage, limit_raised, output ready);
endinterface

### hw/rtl/oldest_first_class_limited_scheduler.sv
// ----------------------------------------------------------------------------
// oldest_first_class_limited_scheduler
// Oldest-first request scheduler with per-class FIFO queues and limits.
//
//   channel  dir  beat contents
//   req      in   op, request_id, class_id, create_time, class_limit
//   rsp      out  status, granted_id, granted_class, granted_time,
//                 found_stage, limit_raised
//
// Submit, complete and cancel scan the record table one entry a cycle through
// its memory read port; a cancel of a queued entry then searches and shifts its
// class queue. A grant picks the oldest eligible class head and shifts that
// queue. rst_n asynchronously clears the state, record stages, class counters
// and limits and response valid. A two-deep command queue and the response
// register let req and rsp stall independently.
// ----------------------------------------------------------------------------
module oldest_first_class_limited_scheduler
    import osch_pkg::*;
#(
    parameter int NUM_CLASSES       = 8,
    parameter int CLASS_QUEUE_DEPTH = 16,
    parameter int TABLE_DEPTH       = 64
)
(
    input  logic       clk,
    input  logic       rst_n,
    osch_req_if.sink   req,
    osch_rsp_if.source rsp
);

    logic front_valid, front_ready;
    cmd_t front_cmd;
    logic back_valid, back_ready;
    cmd_t back_cmd;

    osch_front #(
        .NUM_CLASSES (NUM_CLASSES)
    ) u_front (
        .req       (req),
        .cmd_valid (front_valid),
        .cmd       (front_cmd),
        .cmd_ready (front_ready)
    );

    osch_cmd_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .push_data  (front_cmd),
        .pop_valid  (back_valid),
        .pop_ready  (back_ready),
        .pop_data   (back_cmd)
    );

    osch_back #(
        .NUM_CLASSES       (NUM_CLASSES),
        .CLASS_QUEUE_DEPTH (CLASS_QUEUE_DEPTH),
        .TABLE_DEPTH       (TABLE_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (back_valid),
        .cmd_ready (back_ready),
        .cmd       (back_cmd),
        .rsp       (rsp)
    );

endmodule

### hw/rtl/osch_front.sv
// ----------------------------------------------------------------------------
// osch_front
// Accepts request beats, decodes the operation and flags malformed submits.
// ----------------------------------------------------------------------------
module osch_front
    import osch_pkg::*;
#(
    parameter int NUM_CLASSES = 8
)
(
    osch_req_if.sink   req,
    output logic       cmd_valid,
    output cmd_t       cmd,
    input  logic       cmd_ready
);

    logic cls_out_of_range;

    assign cls_out_of_range = 32'(req.class_id) >= 32'(NUM_CLASSES);

    always_comb
    begin
        cmd.op    = op_t'(req.op);
        cmd.id    = req.request_id;
        cmd.cls   = req.class_id;
        cmd.ctime = req.create_time;
        cmd.limit = req.class_limit;
        // A submit with zero time or an unknown class is rejected without a table scan.
        cmd.bad   = (op_t'(req.op) == OP_SUBMIT) &&
                    ((req.create_time == '0) || cls_out_of_range);
    end

    assign cmd_valid = req.valid;
    assign req.ready = cmd_ready;

endmodule

### hw/rtl/osch_cmd_fifo.sv
// ----------------------------------------------------------------------------
// osch_cmd_fifo
// Short command queue between the front and the back.
// ----------------------------------------------------------------------------
module osch_cmd_fifo
    import osch_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push_valid,
    output logic push_ready,
    input  cmd_t push_data,
    output logic pop_valid,
    input  logic pop_ready,
    output cmd_t pop_data
);

    localparam int PW = $clog2(CMD_FIFO_DEPTH);
    localparam int CW = $clog2(CMD_FIFO_DEPTH + 1);

    cmd_t          mem [CMD_FIFO_DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_push, do_pop;

    assign push_ready = count_reg != CW'(CMD_FIFO_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_data   = mem[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(CMD_FIFO_DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(CMD_FIFO_DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

### hw/rtl/osch_back.sv
// ----------------------------------------------------------------------------
// osch_back
// Sequencer that scans the record table, picks grants and edits class queues.
// ----------------------------------------------------------------------------
module osch_back
    import osch_pkg::*;
#(
    parameter int NUM_CLASSES       = 8,
    parameter int CLASS_QUEUE_DEPTH = 16,
    parameter int TABLE_DEPTH       = 64
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cmd_valid,
    output logic       cmd_ready,
    input  cmd_t       cmd,
    osch_rsp_if.source rsp
);

    localparam int CW   = $clog2(NUM_CLASSES);
    localparam int CSW  = $clog2(NUM_CLASSES + 1);
    localparam int QW   = $clog2(CLASS_QUEUE_DEPTH);
    localparam int QCW  = $clog2(CLASS_QUEUE_DEPTH + 1);
    localparam int TW   = $clog2(TABLE_DEPTH);
    localparam int TCW  = $clog2(TABLE_DEPTH + 1);
    localparam int QA_W = CW + QW;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [TIME_W-1:0] ctime;
        logic [CLS_W-1:0]  cls;
    } rec_t;

    typedef enum logic [11:0] {
        S_IDLE   = 12'b000000000001,
        S_SCAN   = 12'b000000000010,
        S_DECIDE = 12'b000000000100,
        S_G_HEAD = 12'b000000001000,
        S_G_REC  = 12'b000000010000,
        S_G_CMP  = 12'b000000100000,
        S_Q_RD   = 12'b000001000000,
        S_Q_CMP  = 12'b000010000000,
        S_SH_RD  = 12'b000100000000,
        S_SH_WR  = 12'b001000000000,
        S_FIN    = 12'b010000000000,
        S_RESP   = 12'b100000000000
    } state_t;

    // Record table and class queues live in memories.
    rec_t          rec_mem [TABLE_DEPTH];
    logic [TW-1:0] q_mem   [2**QA_W];

    rec_t            rec_q_reg;
    logic [TW-1:0]   q_q_reg;
    logic            rec_re, rec_we, q_re, q_we;
    logic [TW-1:0]   rec_ra, rec_wa;
    rec_t            rec_wd;
    logic [QA_W-1:0] q_ra, q_wa;
    logic [TW-1:0]   q_wd;

    state_t          state_reg, state_next;
    cmd_t            cmd_reg, cmd_next;
    rec_stage_t      stage_reg [TABLE_DEPTH];
    rec_stage_t      stage_next [TABLE_DEPTH];
    logic [QCW-1:0]  qcnt_reg [NUM_CLASSES];
    logic [QCW-1:0]  qcnt_next [NUM_CLASSES];
    logic [LIM_W-1:0] lim_reg [NUM_CLASSES];
    logic [LIM_W-1:0] lim_next [NUM_CLASSES];
    logic [TCW-1:0]  run_reg [NUM_CLASSES];
    logic [TCW-1:0]  run_next [NUM_CLASSES];

    logic [TCW-1:0]  scan_idx_reg, scan_idx_next;
    logic            cmp_vld_reg, cmp_vld_next;
    logic [TW-1:0]   cmp_idx_reg, cmp_idx_next;
    logic            cmp_used_reg, cmp_used_next;
    logic            found_reg, found_next;
    logic [TW-1:0]   found_idx_reg, found_idx_next;
    rec_t            found_rec_reg, found_rec_next;
    logic            ffree_vld_reg, ffree_vld_next;
    logic [TW-1:0]   ffree_idx_reg, ffree_idx_next;
    logic            fdone_vld_reg, fdone_vld_next;
    logic [TW-1:0]   fdone_idx_reg, fdone_idx_next;

    logic [CSW-1:0]  cscan_reg, cscan_next;
    logic            best_vld_reg, best_vld_next;
    logic [CW-1:0]   best_cls_reg, best_cls_next;
    logic [TW-1:0]   best_rec_reg, best_rec_next;
    rec_t            best_data_reg, best_data_next;

    logic [QCW-1:0]  qpos_reg, qpos_next;
    logic [CW-1:0]   work_cls_reg, work_cls_next;
    logic [TW-1:0]   work_rec_reg, work_rec_next;
    logic            do_pop_reg, do_pop_next;

    res_t            res_reg, res_next;
    logic            out_vld_reg, out_vld_next;
    res_t            out_res_reg, out_res_next;

    logic [CW-1:0]   cmd_cidx, found_cidx, cscan_cidx;
    rec_stage_t      found_stage;
    logic [QCW-1:0]  qpos_p1, new_cnt;
    logic [TW-1:0]   submit_rec;
    logic            submit_rec_vld;

    assign cmd_cidx    = CW'(cmd_reg.cls);
    assign found_cidx  = CW'(found_rec_reg.cls);
    assign cscan_cidx  = cscan_reg[CW-1:0];
    assign found_stage = stage_reg[found_idx_reg];
    assign qpos_p1     = qpos_reg + QCW'(1);
    assign new_cnt     = qcnt_reg[work_cls_reg] - (do_pop_reg ? QCW'(1) : QCW'(0));

    always_comb
    begin
        submit_rec     = found_idx_reg;
        submit_rec_vld = 1'b1;
        priority if (found_reg)
        begin
            submit_rec = found_idx_reg;
        end
        else if (ffree_vld_reg)
        begin
            submit_rec = ffree_idx_reg;
        end
        else if (fdone_vld_reg)
        begin
            submit_rec = fdone_idx_reg;
        end
        else
        begin
            submit_rec_vld = 1'b0;
        end
    end

    assign cmd_ready = state_reg == S_IDLE;

    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        stage_next     = stage_reg;
        qcnt_next      = qcnt_reg;
        lim_next       = lim_reg;
        run_next       = run_reg;
        scan_idx_next  = scan_idx_reg;
        cmp_vld_next   = 1'b0;
        cmp_idx_next   = cmp_idx_reg;
        cmp_used_next  = cmp_used_reg;
        found_next     = found_reg;
        found_idx_next = found_idx_reg;
        found_rec_next = found_rec_reg;
        ffree_vld_next = ffree_vld_reg;
        ffree_idx_next = ffree_idx_reg;
        fdone_vld_next = fdone_vld_reg;
        fdone_idx_next = fdone_idx_reg;
        cscan_next     = cscan_reg;
        best_vld_next  = best_vld_reg;
        best_cls_next  = best_cls_reg;
        best_rec_next  = best_rec_reg;
        best_data_next = best_data_reg;
        qpos_next      = qpos_reg;
        work_cls_next  = work_cls_reg;
        work_rec_next  = work_rec_reg;
        do_pop_next    = do_pop_reg;
        res_next       = res_reg;
        out_vld_next   = out_vld_reg;
        out_res_next   = out_res_reg;

        rec_re = 1'b0;
        rec_ra = '0;
        rec_we = 1'b0;
        rec_wa = '0;
        rec_wd = '0;
        q_re   = 1'b0;
        q_ra   = '0;
        q_we   = 1'b0;
        q_wa   = '0;
        q_wd   = '0;

        if (out_vld_reg && rsp.ready)
        begin
            out_vld_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_next = cmd;
                    res_next = '0;
                    if (cmd.op == OP_GRANT)
                    begin
                        cscan_next    = '0;
                        best_vld_next = 1'b0;
                        state_next    = S_G_HEAD;
                    end
                    else if (cmd.bad)
                    begin
                        res_next.status = STS_INVALID;
                        state_next      = S_RESP;
                    end
                    else
                    begin
                        scan_idx_next  = '0;
                        found_next     = 1'b0;
                        ffree_vld_next = 1'b0;
                        fdone_vld_next = 1'b0;
                        state_next     = S_SCAN;
                    end
                end
            end

            S_SCAN:
            begin
                // One record address is issued per cycle; its data is compared in the next cycle.
                if (scan_idx_reg != TCW'(TABLE_DEPTH))
                begin
                    rec_re        = 1'b1;
                    rec_ra        = scan_idx_reg[TW-1:0];
                    cmp_vld_next  = 1'b1;
                    cmp_idx_next  = scan_idx_reg[TW-1:0];
                    cmp_used_next = stage_reg[scan_idx_reg[TW-1:0]] != STG_FREE;
                    if (!ffree_vld_reg && (stage_reg[scan_idx_reg[TW-1:0]] == STG_FREE))
                    begin
                        ffree_vld_next = 1'b1;
                        ffree_idx_next = scan_idx_reg[TW-1:0];
                    end
                    if (!fdone_vld_reg && (stage_reg[scan_idx_reg[TW-1:0]] == STG_DONE))
                    begin
                        fdone_vld_next = 1'b1;
                        fdone_idx_next = scan_idx_reg[TW-1:0];
                    end
                    scan_idx_next = scan_idx_reg + TCW'(1);
                end
                else if (!cmp_vld_reg)
                begin
                    state_next = S_DECIDE;
                end
                if (cmp_vld_reg && cmp_used_reg && (rec_q_reg.id == cmd_reg.id))
                begin
                    found_next     = 1'b1;
                    found_idx_next = cmp_idx_reg;
                    found_rec_next = rec_q_reg;
                end
            end

            S_DECIDE:
            begin
                state_next = S_RESP;
                unique case (cmd_reg.op)
                    OP_SUBMIT:
                    begin
                        priority if (found_reg && (found_stage != STG_DONE))
                        begin
                            res_next.status = STS_INVALID;
                        end
                        else if (qcnt_reg[cmd_cidx] >= QCW'(CLASS_QUEUE_DEPTH))
                        begin
                            res_next.status = STS_FULL;
                        end
                        else if (!submit_rec_vld)
                        begin
                            res_next.status = STS_FULL;
                        end
                        else
                        begin
                            rec_we    = 1'b1;
                            rec_wa    = submit_rec;
                            rec_wd.id = cmd_reg.id;
                            rec_wd.ctime = cmd_reg.ctime;
                            rec_wd.cls = cmd_reg.cls;
                            stage_next[submit_rec] = STG_QUEUED;
                            q_we = 1'b1;
                            q_wa = {cmd_cidx, qcnt_reg[cmd_cidx][QW-1:0]};
                            q_wd = submit_rec;
                            qcnt_next[cmd_cidx] = qcnt_reg[cmd_cidx] + QCW'(1);
                            lim_next[cmd_cidx]  = cmd_reg.limit;
                            res_next.raised = limit_raised(lim_reg[cmd_cidx], cmd_reg.limit);
                        end
                    end
                    OP_COMPLETE:
                    begin
                        if (!found_reg ||
                            ((found_stage != STG_RUN) && (found_stage != STG_RUN_ADV)))
                        begin
                            res_next.status = STS_NOT_FOUND;
                        end
                        else
                        begin
                            stage_next[found_idx_reg] = STG_DONE;
                            if (run_reg[found_cidx] != '0)
                            begin
                                run_next[found_cidx] = run_reg[found_cidx] - TCW'(1);
                            end
                            if (qcnt_reg[found_cidx] != '0)
                            begin
                                lim_next[found_cidx] = cmd_reg.limit;
                                res_next.raised =
                                    limit_raised(lim_reg[found_cidx], cmd_reg.limit);
                            end
                            res_next.id    = found_rec_reg.id;
                            res_next.cls   = CLS_W'(found_cidx);
                            res_next.ctime = found_rec_reg.ctime;
                        end
                    end
                    OP_CANCEL:
                    begin
                        if (!found_reg)
                        begin
                            res_next.status = STS_NOT_FOUND;
                        end
                        else
                        begin
                            res_next.id    = found_rec_reg.id;
                            res_next.cls   = CLS_W'(found_cidx);
                            res_next.ctime = found_rec_reg.ctime;
                            priority if (found_stage == STG_QUEUED)
                            begin
                                res_next.fstage = FS_QUEUED;
                                work_cls_next   = found_cidx;
                                work_rec_next   = found_idx_reg;
                                qpos_next       = '0;
                                do_pop_next     = 1'b0;
                                state_next      = S_Q_RD;
                            end
                            else if ((found_stage == STG_RUN) || (found_stage == STG_RUN_ADV))
                            begin
                                stage_next[found_idx_reg] = STG_RUN_ADV;
                                res_next.fstage = FS_RUNNING;
                            end
                            else
                            begin
                                res_next.fstage = FS_DONE;
                            end
                        end
                    end
                    default:
                    begin
                        res_next.status = STS_INVALID;
                    end
                endcase
            end

            S_G_HEAD:
            begin
                if (cscan_reg == CSW'(NUM_CLASSES))
                begin
                    if (best_vld_reg)
                    begin
                        work_cls_next   = best_cls_reg;
                        work_rec_next   = best_rec_reg;
                        qpos_next       = '0;
                        do_pop_next     = 1'b1;
                        res_next.id     = best_data_reg.id;
                        res_next.cls    = CLS_W'(best_cls_reg);
                        res_next.ctime  = best_data_reg.ctime;
                        state_next      = S_SH_RD;
                    end
                    else
                    begin
                        res_next.status = STS_NONE_ELIGIBLE;
                        state_next      = S_RESP;
                    end
                end
                else if ((qcnt_reg[cscan_cidx] != '0) &&
                         ((lim_reg[cscan_cidx] == '0) ||
                          (32'(run_reg[cscan_cidx]) < 32'(lim_reg[cscan_cidx]))))
                begin
                    q_re       = 1'b1;
                    q_ra       = {cscan_cidx, QW'(0)};
                    state_next = S_G_REC;
                end
                else
                begin
                    cscan_next = cscan_reg + CSW'(1);
                end
            end

            S_G_REC:
            begin
                rec_re     = 1'b1;
                rec_ra     = q_q_reg;
                state_next = S_G_CMP;
            end

            S_G_CMP:
            begin
                // Strictly older wins, so ties stay with the lower class.
                if (!best_vld_reg || (rec_q_reg.ctime < best_data_reg.ctime))
                begin
                    best_vld_next  = 1'b1;
                    best_cls_next  = cscan_cidx;
                    best_rec_next  = q_q_reg;
                    best_data_next = rec_q_reg;
                end
                cscan_next = cscan_reg + CSW'(1);
                state_next = S_G_HEAD;
            end

            S_Q_RD:
            begin
                if (qpos_reg < qcnt_reg[work_cls_reg])
                begin
                    q_re       = 1'b1;
                    q_ra       = {work_cls_reg, qpos_reg[QW-1:0]};
                    state_next = S_Q_CMP;
                end
                else
                begin
                    state_next = S_FIN;
                end
            end

            S_Q_CMP:
            begin
                if (q_q_reg == work_rec_reg)
                begin
                    do_pop_next = 1'b1;
                    state_next  = S_SH_RD;
                end
                else
                begin
                    qpos_next  = qpos_p1;
                    state_next = S_Q_RD;
                end
            end

            S_SH_RD:
            begin
                if (qpos_p1 < qcnt_reg[work_cls_reg])
                begin
                    q_re       = 1'b1;
                    q_ra       = {work_cls_reg, qpos_p1[QW-1:0]};
                    state_next = S_SH_WR;
                end
                else
                begin
                    state_next = S_FIN;
                end
            end

            S_SH_WR:
            begin
                q_we       = 1'b1;
                q_wa       = {work_cls_reg, qpos_reg[QW-1:0]};
                q_wd       = q_q_reg;
                qpos_next  = qpos_p1;
                state_next = S_SH_RD;
            end

            S_FIN:
            begin
                qcnt_next[work_cls_reg] = new_cnt;
                if (cmd_reg.op == OP_GRANT)
                begin
                    stage_next[work_rec_reg] = STG_RUN;
                    run_next[work_cls_reg]   = run_reg[work_cls_reg] + TCW'(1);
                    if (new_cnt == '0)
                    begin
                        lim_next[work_cls_reg] = '0;
                    end
                end
                else
                begin
                    stage_next[work_rec_reg] = STG_DONE;
                    if (new_cnt == '0)
                    begin
                        lim_next[work_cls_reg] = '0;
                    end
                    else
                    begin
                        lim_next[work_cls_reg] = cmd_reg.limit;
                        res_next.raised = limit_raised(lim_reg[work_cls_reg], cmd_reg.limit);
                    end
                end
                state_next = S_RESP;
            end

            S_RESP:
            begin
                if (!out_vld_reg || rsp.ready)
                begin
                    out_vld_next = 1'b1;
                    out_res_next = res_reg;
                    state_next   = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            out_vld_reg <= 1'b0;
            for (int i = 0; i < TABLE_DEPTH; i++)
            begin
                stage_reg[i] <= STG_FREE;
            end
            for (int c = 0; c < NUM_CLASSES; c++)
            begin
                qcnt_reg[c] <= '0;
                lim_reg[c]  <= '0;
                run_reg[c]  <= '0;
            end
        end
        else
        begin
            state_reg   <= state_next;
            out_vld_reg <= out_vld_next;
            stage_reg   <= stage_next;
            qcnt_reg    <= qcnt_next;
            lim_reg     <= lim_next;
            run_reg     <= run_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg       <= cmd_next;
        scan_idx_reg  <= scan_idx_next;
        cmp_vld_reg   <= cmp_vld_next;
        cmp_idx_reg   <= cmp_idx_next;
        cmp_used_reg  <= cmp_used_next;
        found_reg     <= found_next;
        found_idx_reg <= found_idx_next;
        found_rec_reg <= found_rec_next;
        ffree_vld_reg <= ffree_vld_next;
        ffree_idx_reg <= ffree_idx_next;
        fdone_vld_reg <= fdone_vld_next;
        fdone_idx_reg <= fdone_idx_next;
        cscan_reg     <= cscan_next;
        best_vld_reg  <= best_vld_next;
        best_cls_reg  <= best_cls_next;
        best_rec_reg  <= best_rec_next;
        best_data_reg <= best_data_next;
        qpos_reg      <= qpos_next;
        work_cls_reg  <= work_cls_next;
        work_rec_reg  <= work_rec_next;
        do_pop_reg    <= do_pop_next;
        res_reg       <= res_next;
        out_res_reg   <= out_res_next;
    end

    always_ff @(posedge clk)
    begin
        if (rec_we)
        begin
            rec_mem[rec_wa] <= rec_wd;
        end
        if (rec_re)
        begin
            rec_q_reg <= rec_mem[rec_ra];
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_we)
        begin
            q_mem[q_wa] <= q_wd;
        end
        if (q_re)
        begin
            q_q_reg <= q_mem[q_ra];
        end
    end

    assign rsp.valid         = out_vld_reg;
    assign rsp.status        = out_res_reg.status;
    assign rsp.granted_id    = out_res_reg.id;
    assign rsp.granted_class = out_res_reg.cls;
    assign rsp.granted_time  = out_res_reg.ctime;
    assign rsp.found_stage   = out_res_reg.fstage;
    assign rsp.limit_raised  = out_res_reg.raised;

endmodule

### dv/tb_oldest_first_class_limited_scheduler.sv
// ----------------------------------------------------------------------------
// tb_oldest_first_class_limited_scheduler
// Drives submit, grant, complete and cancel beats into the scheduler. A
// behavioral copy of the scheduler predicts every response, and a scoreboard
// compares the responses in order. Both channels idle at random, and one
// long receiver hold-off fills the block.
// ----------------------------------------------------------------------------
module tb_oldest_first_class_limited_scheduler;
    import osch_pkg::*;

    localparam int NCLS  = 8;
    localparam int QDEP  = 16;
    localparam int TDEP  = 64;
    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct packed {
        status_t           status;
        logic [ID_W-1:0]   id;
        logic [CLS_W-1:0]  cls;
        logic [TIME_W-1:0] ctime;
        logic [1:0]        fstage;
        logic              raised;
    } sched_rsp_t;

    // Behavioral copy of the scheduler state.
    class sched_scoreboard;
        int unsigned q_slot[NCLS][QDEP];
        int unsigned q_cnt[NCLS];
        logic [7:0]  lim[NCLS];
        int unsigned run_cnt[NCLS];
        logic [15:0] rec_id[TDEP];
        logic [31:0] rec_time[TDEP];
        int unsigned rec_cls[TDEP];
        rec_stage_t  rec_stg[TDEP];
        sched_rsp_t  pending[$];
        int          mismatches;

        function new();
            foreach (q_cnt[c])
            begin
                q_cnt[c] = 0;
                lim[c] = '0;
                run_cnt[c] = 0;
            end
            foreach (rec_stg[i])
                rec_stg[i] = STG_FREE;
            mismatches = 0;
        endfunction

        function int lookup(logic [15:0] id);
            for (int i = 0; i < TDEP; i++)
                if (rec_stg[i] != STG_FREE && rec_id[i] == id)
                    return i;
            return -1;
        endfunction

        function logic refresh(int c, logic [7:0] v);
            logic r;
            r = 1'b0;
            if (lim[c] != v)
            begin
                r = (v == 0) || (lim[c] != 0 && v > lim[c]);
                lim[c] = v;
            end
            return r;
        endfunction

        function void drop(int c, int pos);
            for (int k = pos; k + 1 < q_cnt[c]; k++)
                q_slot[c][k] = q_slot[c][k + 1];
            q_cnt[c]--;
        endfunction

        // Notes one accepted request beat and queues its expected response.
        function void note_request(op_t op, logic [15:0] id, logic [2:0] cls,
                                   logic [31:0] tm, logic [7:0] lv);
            sched_rsp_t e;
            int r;
            int best;
            int unsigned h;
            int unsigned c;
            logic [31:0] best_time;
            e = '0;
            e.status = STS_OK;
            best = -1;
            best_time = '0;
            h = 0;
            case (op)
                OP_SUBMIT:
                begin
                    r = lookup(id);
                    if (tm == 0)
                        e.status = STS_INVALID;
                    else if (r >= 0 && rec_stg[r] != STG_DONE)
                        e.status = STS_INVALID;
                    else if (q_cnt[cls] >= QDEP)
                        e.status = STS_FULL;
                    else
                    begin
                        for (int i = 0; i < TDEP && r < 0; i++)
                            if (rec_stg[i] == STG_FREE) r = i;
                        for (int i = 0; i < TDEP && r < 0; i++)
                            if (rec_stg[i] == STG_DONE) r = i;
                        if (r < 0)
                            e.status = STS_FULL;
                        else
                        begin
                            rec_id[r] = id;
                            rec_time[r] = tm;
                            rec_cls[r] = 32'(cls);
                            rec_stg[r] = STG_QUEUED;
                            q_slot[cls][q_cnt[cls]] = r;
                            q_cnt[cls]++;
                            e.raised = refresh(cls, lv);
                        end
                    end
                end
                OP_GRANT:
                begin
                    for (int k = 0; k < NCLS; k++)
                    begin
                        if (q_cnt[k] == 0) continue;
                        if (lim[k] != 0 && run_cnt[k] >= lim[k]) continue;
                        if (best < 0 || rec_time[q_slot[k][0]] < best_time)
                        begin
                            best = k;
                            h = q_slot[k][0];
                            best_time = rec_time[h];
                        end
                    end
                    if (best < 0)
                        e.status = STS_NONE_ELIGIBLE;
                    else
                    begin
                        drop(best, 0);
                        rec_stg[h] = STG_RUN;
                        run_cnt[best]++;
                        if (q_cnt[best] == 0) lim[best] = '0;
                        e.id = rec_id[h];
                        e.cls = 3'(best);
                        e.ctime = rec_time[h];
                    end
                end
                OP_COMPLETE:
                begin
                    r = lookup(id);
                    if (r < 0 || (rec_stg[r] != STG_RUN && rec_stg[r] != STG_RUN_ADV))
                        e.status = STS_NOT_FOUND;
                    else
                    begin
                        c = rec_cls[r];
                        rec_stg[r] = STG_DONE;
                        if (run_cnt[c] != 0) run_cnt[c]--;
                        if (q_cnt[c] != 0) e.raised = refresh(c, lv);
                        e.id = rec_id[r];
                        e.cls = 3'(c);
                        e.ctime = rec_time[r];
                    end
                end
                default:
                begin
                    r = lookup(id);
                    if (r < 0)
                        e.status = STS_NOT_FOUND;
                    else
                    begin
                        c = rec_cls[r];
                        e.id = rec_id[r];
                        e.cls = 3'(c);
                        e.ctime = rec_time[r];
                        if (rec_stg[r] == STG_QUEUED)
                        begin
                            for (int k = 0; k < q_cnt[c]; k++)
                                if (q_slot[c][k] == r)
                                begin
                                    drop(c, k);
                                    break;
                                end
                            rec_stg[r] = STG_DONE;
                            if (q_cnt[c] == 0) lim[c] = '0;
                            else e.raised = refresh(c, lv);
                            e.fstage = FS_QUEUED;
                        end
                        else if (rec_stg[r] == STG_RUN || rec_stg[r] == STG_RUN_ADV)
                        begin
                            rec_stg[r] = STG_RUN_ADV;
                            e.fstage = FS_RUNNING;
                        end
                        else
                            e.fstage = FS_DONE;
                    end
                end
            endcase
            pending.insert(pending.size(), e);
        endfunction

        // Checks one accepted response beat against the oldest expectation.
        function void check_response(sched_rsp_t got);
            sched_rsp_t e;
            if (pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected response beat: %p", got);
                return;
            end
            e = pending[0];
            pending.delete(0);
            if (got !== e)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("response mismatch: expected %p, got %p", e, got);
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    osch_req_if req ();
    osch_rsp_if rsp ();

    oldest_first_class_limited_scheduler DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req.sink),
        .rsp   (rsp.source)
    );

    sched_scoreboard sb;
    int   send_idle_pct;
    int   recv_idle_pct;
    int   hold_off;
    int   quiet_cycles;
    logic [15:0] id_pool[$];

    initial clk = 1'b0;
    always #1 clk = ~clk;

    initial
    begin
        sb = new();
        rst_n = 1'b0;
        req.valid = 1'b0;
        req.op = '0;
        req.request_id = '0;
        req.class_id = '0;
        req.create_time = '0;
        req.class_limit = '0;
        rsp.ready = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Receiver side: random stalls, a long hold-off on request, checks each beat.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rsp.valid && rsp.ready)
                sb.check_response({status_t'(rsp.status), rsp.granted_id,
                                   rsp.granted_class, rsp.granted_time,
                                   rsp.found_stage, rsp.limit_raised});
            if (hold_off > 0)
            begin
                hold_off <= hold_off - 1;
                rsp.ready <= 1'b0;
            end
            else
                rsp.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Counts cycles without any accepted beat.
    always @(posedge clk)
    begin
        if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Valid stays high from one beat to the next unless the sender idles.
    task automatic send_beat(op_t op, logic [15:0] id, logic [2:0] cls,
                             logic [31:0] tm, logic [7:0] lv);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req.valid <= 1'b0;
            @(posedge clk);
        end
        req.valid <= 1'b1;
        req.op <= op;
        req.request_id <= id;
        req.class_id <= cls;
        req.create_time <= tm;
        req.class_limit <= lv;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        sb.note_request(op, id, cls, tm, lv);
    endtask

    // Ids come mostly from a small pool so that they meet again in the table.
    function automatic logic [15:0] pick_id();
        if (id_pool.size() == 0 || $urandom_range(9) == 0)
            return 16'($urandom);
        return id_pool[$urandom_range(id_pool.size() - 1)];
    endfunction

    function automatic logic [31:0] pick_time();
        case ($urandom_range(5))
            0: return 32'hFFFF_FFFF - $urandom_range(3);
            1: return 32'($urandom_range(1, 8));
            default: return $urandom | 32'h1;
        endcase
    endfunction

    function automatic logic [7:0] pick_limit();
        case ($urandom_range(4))
            0: return 8'd0;
            1: return 8'hFF;
            default: return 8'($urandom_range(1, 4));
        endcase
    endfunction

    task automatic random_beat();
        int sel;
        sel = $urandom_range(99);
        if (sel < 40)
            send_beat(OP_SUBMIT, pick_id(), 3'($urandom), ($urandom_range(30) == 0) ?
                      32'd0 : pick_time(), pick_limit());
        else if (sel < 65)
            send_beat(OP_GRANT, 16'($urandom), 3'($urandom), $urandom, 8'($urandom));
        else if (sel < 85)
            send_beat(OP_COMPLETE, pick_id(), 3'($urandom), $urandom, pick_limit());
        else
            send_beat(OP_CANCEL, pick_id(), 3'($urandom), $urandom, pick_limit());
    endtask

    initial
    begin
        hold_off = 0;
        quiet_cycles = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        for (int i = 0; i < 48; i++)
            id_pool.insert(id_pool.size(), 16'($urandom));
        id_pool[0] = 16'h0000;
        id_pool[1] = 16'hFFFF;
        @(posedge rst_n);
        @(posedge clk);

        // Directed part.
        send_beat(OP_GRANT, 16'h0, 3'd0, 32'd0, 8'd0);
        send_beat(OP_SUBMIT, 16'h0001, 3'd0, 32'd0, 8'd0);
        send_beat(OP_SUBMIT, 16'h0000, 3'd7, 32'hFFFF_FFFF, 8'hFF);
        send_beat(OP_SUBMIT, 16'hFFFF, 3'd0, 32'd1, 8'd1);
        send_beat(OP_SUBMIT, 16'hFFFF, 3'd2, 32'd5, 8'd0);
        send_beat(OP_SUBMIT, 16'h0002, 3'd1, 32'd1, 8'd2);
        send_beat(OP_SUBMIT, 16'h0003, 3'd0, 32'd9, 8'd3);
        send_beat(OP_GRANT, 16'h0, 3'd0, 32'd0, 8'd0);
        send_beat(OP_GRANT, 16'h0, 3'd0, 32'd0, 8'd0);
        send_beat(OP_GRANT, 16'h0, 3'd0, 32'd0, 8'd0);
        send_beat(OP_CANCEL, 16'h0003, 3'd0, 32'd0, 8'd0);
        send_beat(OP_CANCEL, 16'hFFFF, 3'd0, 32'd0, 8'd0);
        send_beat(OP_COMPLETE, 16'hFFFF, 3'd0, 32'd0, 8'd5);
        send_beat(OP_CANCEL, 16'hFFFF, 3'd0, 32'd0, 8'd0);
        send_beat(OP_COMPLETE, 16'h1234, 3'd0, 32'd0, 8'd0);
        send_beat(OP_CANCEL, 16'h1234, 3'd0, 32'd0, 8'd0);
        send_beat(OP_SUBMIT, 16'hFFFF, 3'd3, 32'd4, 8'd0);
        for (int i = 0; i < 17; i++)
            send_beat(OP_SUBMIT, 16'(16'h100 + i), 3'd5, 32'(100 + i), 8'(i));

        // Random part in three idling phases; a long hold-off in the first.
        for (int ph = 0; ph < 3; ph++)
        begin
            send_idle_pct = (ph == 0) ? 25 : (ph == 1) ? 84 : 0;
            recv_idle_pct = (ph == 0) ? 84 : (ph == 1) ? 25 : 0;
            if (ph == 0)
                hold_off = 400;
            for (int n = 0; n < 600; n++)
                random_beat();
        end
        req.valid <= 1'b0;

        send_idle_pct = 0;
        recv_idle_pct = 0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

### sim.f
hw/rtl/osch_pkg.sv
hw/rtl/osch_ifs.sv
hw/rtl/osch_front.sv
hw/rtl/osch_cmd_fifo.sv
hw/rtl/osch_back.sv
hw/rtl/oldest_first_class_limited_scheduler.sv
dv/tb_oldest_first_class_limited_scheduler.sv
